// ----- rtl/core/json_token_classifier_assert.svh -----
// Assertion macros shared by the checker files of the token classifier.
// Every macro samples on the rising edge of i_clk and is switched off while
// i_rst_n is low, so the module that uses them must have both signals.
`ifndef JSON_TOKEN_CLASSIFIER_ASSERT_SVH
`define JSON_TOKEN_CLASSIFIER_ASSERT_SVH

// Implication in the same cycle.
`define JTC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define JTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/jtc_pkg.sv -----
`timescale 1ns / 1ps

package jtc_pkg;

    // Width of the internal byte offset counter; offsets leave in their low 32 bits.
    localparam int OFFSET_WIDTH = 32;
    localparam int OUT_OFF_WIDTH = 32;

    // Depth of the bundle queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

    typedef logic [OFFSET_WIDTH-1:0] t_offset;
    typedef logic [OUT_OFF_WIDTH-1:0] t_out_offset;

    // Token kinds as they appear on the output.
    localparam logic [3:0] KIND_END       = 4'd0;
    localparam logic [3:0] KIND_COLON     = 4'd1;
    localparam logic [3:0] KIND_LBRACKET  = 4'd2;
    localparam logic [3:0] KIND_RBRACKET  = 4'd3;
    localparam logic [3:0] KIND_COMMA     = 4'd4;
    localparam logic [3:0] KIND_LBRACE    = 4'd5;
    localparam logic [3:0] KIND_RBRACE    = 4'd6;
    localparam logic [3:0] KIND_NUM       = 4'd7;
    localparam logic [3:0] KIND_SIGNED    = 4'd8;
    localparam logic [3:0] KIND_FLOAT     = 4'd9;
    localparam logic [3:0] KIND_NUMEXP    = 4'd10;
    localparam logic [3:0] KIND_FLOATEXP  = 4'd11;
    localparam logic [3:0] KIND_WORD      = 4'd12;
    localparam logic [3:0] KIND_STRING    = 4'd13;

    // One result item.
    typedef struct packed {
        logic [3:0]  kind;
        t_out_offset start_off;
        t_out_offset end_off;
        logic        last;
    } t_token;

    // All results caused by one input item: one token, or two when second is set.
    typedef struct packed {
        logic   second;
        t_token tok0;
        t_token tok1;
    } t_bundle;

    // Low 32 bits of an offset, zero extended when the counter is narrower.
    function automatic t_out_offset to_out_off(input t_offset v);
        logic [OFFSET_WIDTH+OUT_OFF_WIDTH-1:0] wide;
        wide = {{OUT_OFF_WIDTH{1'b0}}, v};
        return wide[OUT_OFF_WIDTH-1:0];
    endfunction

endpackage

// ----- rtl/core/jtc_in_if.sv -----
`timescale 1ns / 1ps

// Input byte channel.
interface jtc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ----- rtl/core/jtc_out_if.sv -----
`timescale 1ns / 1ps

// Output token channel.
interface jtc_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_end;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_end, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_end, input last_of_run, output ready);
endinterface

// ----- rtl/core/json_token_classifier.sv -----
`timescale 1ns / 1ps

// JSON token classifier.
// Input channel i_in carries one text byte per transfer, or an end mark when
// end_of_text is set. Output channel o_out carries tokens: kind, start and end
// byte offsets, and last_of_run on the final token caused by one input.
// One byte is accepted per cycle while the queue has room. A token completed
// by a transfer is written to the queue, then to the output register.
// Results leave at one per cycle while o_out.ready is high, so an input that
// gives two tokens (a value closed by punctuation, or an end mark with a
// pending token) takes two output transfers; input keeps flowing while the
// queue has room. The queue holds four bundles of results; i_in.ready drops
// only when it is full, which happens when the receiver stalls o_out.ready.
// Reset clears the scan state to idle, both offsets to zero, and empties the
// queue and output register; the block accepts bytes as soon as reset
// is released.
module json_token_classifier (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jtc_in_if.sink     i_in,
    jtc_out_if.source  o_out
);
    import jtc_pkg::*;

    logic    push;
    logic    full;
    logic    pop;
    logic    q_valid;
    t_bundle push_bundle;
    t_bundle q_bundle;

    // Byte scanner and classifier.
    jtc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_full   (full),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    // Decoupling queue.
    jtc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .o_full   (full),
        .i_pop    (pop),
        .o_valid  (q_valid),
        .o_bundle (q_bundle)
    );

    // Token sender.
    jtc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_bundle (q_bundle),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

// ----- rtl/core/jtc_front.sv -----
`timescale 1ns / 1ps

// Front part: takes one byte per transfer, updates the scan state and
// hands the tokens that the byte completes to the queue as one bundle.
module jtc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    jtc_in_if.sink            i_in,
    input  logic              i_full,
    output logic              o_push,
    output jtc_pkg::t_bundle  o_bundle
);
    import jtc_pkg::*;

    // Scan modes.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_VALUE = 2'd1;
    localparam logic [1:0] MODE_STR   = 2'd2;
    localparam logic [1:0] MODE_ESC   = 2'd3;

    // Run classes.
    localparam logic [3:0] CLS_NUM      = 4'd0;
    localparam logic [3:0] CLS_SIGNED   = 4'd1;
    localparam logic [3:0] CLS_FLOAT    = 4'd2;
    localparam logic [3:0] CLS_NUMEXP   = 4'd3;
    localparam logic [3:0] CLS_FLOATEXP = 4'd4;
    localparam logic [3:0] CLS_WORD     = 4'd8;
    localparam logic [3:0] CLS_STRING   = 4'd9;
    localparam logic [3:0] CLS_NONE     = 4'd15;

    // Character codes.
    localparam logic [7:0] CH_SPACE_END = 8'h21;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_MINUS     = 8'h2D;
    localparam logic [7:0] CH_PLUS      = 8'h2B;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOW_E     = 8'h65;
    localparam logic [7:0] CH_UP_E      = 8'h45;
    localparam logic [7:0] CH_LOW_A     = 8'h61;
    localparam logic [7:0] CH_LOW_Z     = 8'h7A;
    localparam logic [7:0] CH_UP_A      = 8'h41;
    localparam logic [7:0] CH_UP_Z      = 8'h5A;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

    typedef struct packed {
        logic [3:0] cls;
        logic       ends;
    } t_cls_step;

    // Whitespace covers all bytes up to space and every byte with the top bit set.
    function automatic logic is_space(input logic [7:0] b);
        return (b < CH_SPACE_END) || b[7];
    endfunction

    // Punctuation decoder; KIND_END means not a punctuation byte.
    function automatic logic [3:0] punct_kind(input logic [7:0] b);
        logic [3:0] k;
        unique case (b)
            CH_COLON:    k = KIND_COLON;
            CH_LBRACKET: k = KIND_LBRACKET;
            CH_RBRACKET: k = KIND_RBRACKET;
            CH_COMMA:    k = KIND_COMMA;
            CH_LBRACE:   k = KIND_LBRACE;
            CH_RBRACE:   k = KIND_RBRACE;
            default:     k = KIND_END;
        endcase
        return k;
    endfunction

    // Token kind of a finished run.
    function automatic logic [3:0] value_kind(input logic [3:0] c);
        logic [3:0] k;
        if (c <= CLS_FLOATEXP) begin
            k = KIND_NUM + c;
        end else if (c == CLS_WORD) begin
            k = KIND_WORD;
        end else begin
            k = KIND_STRING;
        end
        return k;
    endfunction

    // Class promotion for one run byte; ends is set when the token closes on it.
    function automatic t_cls_step classify(input logic [3:0] c, input logic [7:0] b);
        t_cls_step r;
        logic      none;
        logic      is_alpha;
        none = (c == CLS_NONE);
        is_alpha = (b == CH_UNDERSCORE) || (b >= CH_LOW_A && b <= CH_LOW_Z)
                   || (b >= CH_UP_A && b <= CH_UP_Z);
        r.cls = c;
        r.ends = 1'b0;
        if (c == CLS_STRING) begin
            r.cls = c;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (none) r.cls = CLS_NUM;
        end else if (b == CH_MINUS || b == CH_PLUS) begin
            r.cls = CLS_STRING;
        end else if (b == CH_DOT) begin
            r.cls = (none || c < CLS_FLOAT) ? CLS_FLOAT : CLS_STRING;
        end else if (b == CH_LOW_E || b == CH_UP_E) begin
            if (none || c < CLS_FLOAT) begin
                r.cls = CLS_NUMEXP;
                r.ends = 1'b1;
            end else if (c < CLS_NUMEXP) begin
                r.cls = CLS_FLOATEXP;
                r.ends = 1'b1;
            end else if (c < CLS_WORD) begin
                r.cls = CLS_WORD;
            end
        end else if (is_alpha) begin
            if (none || c < CLS_WORD) r.cls = CLS_WORD;
        end else begin
            r.cls = CLS_STRING;
        end
        return r;
    endfunction

    function automatic t_token make_tok(input logic [3:0] k, input t_offset s,
                                        input t_offset e);
        t_token t;
        t.kind = k;
        t.start_off = to_out_off(s);
        t.end_off = to_out_off(e);
        t.last = 1'b1;
        return t;
    endfunction

    logic [1:0] r_mode, n_mode;
    logic [3:0] r_cls, n_cls;
    t_offset    r_start, n_start;
    t_offset    r_pos, n_pos;

    logic       accept;
    logic       has_tok;
    t_bundle    bundle;
    t_offset    nxt;
    logic [7:0] b;
    logic [3:0] pk;
    t_cls_step  step;

    assign i_in.ready = !i_full;
    assign accept = i_in.valid && !i_full;
    assign nxt = r_pos + t_offset'(1);
    assign b = i_in.text_byte;
    assign pk = punct_kind(b);
    assign step = classify((r_mode == MODE_IDLE) ? CLS_NONE : r_cls, b);

    // Next scan state and the tokens completed by this item.
    always_comb begin
        n_mode = r_mode;
        n_cls = r_cls;
        n_start = r_start;
        n_pos = nxt;
        has_tok = 1'b0;
        bundle.second = 1'b0;
        bundle.tok0 = make_tok(KIND_END, r_pos, r_pos);
        bundle.tok1 = make_tok(KIND_END, r_pos, r_pos);
        if (i_in.end_of_text) begin
            // Flush the pending token, then report the end.
            has_tok = 1'b1;
            n_pos = r_pos;
            n_mode = MODE_IDLE;
            n_cls = CLS_NONE;
            if (r_mode == MODE_VALUE) begin
                bundle.second = 1'b1;
                bundle.tok0 = make_tok(value_kind(r_cls), r_start, r_pos);
            end else if (r_mode == MODE_STR || r_mode == MODE_ESC) begin
                bundle.second = 1'b1;
                bundle.tok0 = make_tok(KIND_STRING, r_start, r_pos);
            end
        end else begin
            unique case (r_mode)
                MODE_IDLE: begin
                    if (is_space(b)) begin
                        n_mode = MODE_IDLE;
                    end else if (pk != KIND_END) begin
                        has_tok = 1'b1;
                        bundle.tok0 = make_tok(pk, r_pos, nxt);
                    end else if (b == CH_QUOTE) begin
                        n_mode = MODE_STR;
                        n_start = nxt;
                    end else if (b == CH_MINUS || b == CH_PLUS) begin
                        n_mode = MODE_VALUE;
                        n_cls = CLS_SIGNED;
                        n_start = r_pos;
                    end else begin
                        n_start = r_pos;
                        if (step.ends) begin
                            has_tok = 1'b1;
                            bundle.tok0 = make_tok(value_kind(step.cls), r_pos, nxt);
                            n_cls = CLS_NONE;
                        end else begin
                            n_mode = MODE_VALUE;
                            n_cls = step.cls;
                        end
                    end
                end
                MODE_VALUE: begin
                    if (is_space(b) || pk != KIND_END) begin
                        has_tok = 1'b1;
                        bundle.tok0 = make_tok(value_kind(r_cls), r_start, r_pos);
                        if (pk != KIND_END) begin
                            bundle.second = 1'b1;
                            bundle.tok1 = make_tok(pk, r_pos, nxt);
                        end
                        n_mode = MODE_IDLE;
                        n_cls = CLS_NONE;
                    end else if (step.ends) begin
                        has_tok = 1'b1;
                        bundle.tok0 = make_tok(value_kind(step.cls), r_start, nxt);
                        n_mode = MODE_IDLE;
                        n_cls = CLS_NONE;
                    end else begin
                        n_cls = step.cls;
                    end
                end
                MODE_STR: begin
                    if (b == CH_QUOTE) begin
                        has_tok = 1'b1;
                        bundle.tok0 = make_tok(KIND_STRING, r_start, r_pos);
                        n_mode = MODE_IDLE;
                    end else if (b == CH_BSLASH) begin
                        n_mode = MODE_ESC;
                    end
                end
                MODE_ESC: begin
                    n_mode = MODE_STR;
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
        // The first token is the last of its run only when no second follows.
        bundle.tok0.last = !bundle.second;
    end

    assign o_push = accept && has_tok;
    assign o_bundle = bundle;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_cls <= CLS_NONE;
            r_start <= '0;
            r_pos <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_cls <= n_cls;
            r_start <= n_start;
            r_pos <= n_pos;
        end
    end

endmodule

// ----- rtl/core/jtc_queue.sv -----
`timescale 1ns / 1ps

// Short queue of token bundles between the front and back parts.
module jtc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  jtc_pkg::t_bundle  i_bundle,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output jtc_pkg::t_bundle  o_bundle
);
    import jtc_pkg::*;

    t_bundle               r_entries [QUEUE_DEPTH];
    logic [QPTR_WIDTH-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_WIDTH-1:0] r_count, n_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full = (r_count == QCNT_WIDTH'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_bundle = r_entries[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && o_valid;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                       : r_wr_ptr + QPTR_WIDTH'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                       : r_rd_ptr + QPTR_WIDTH'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_WIDTH'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_bundle;
        end
    end

endmodule

// ----- rtl/core/jtc_back.sv -----
`timescale 1ns / 1ps

// Back part: takes bundles from the queue and sends their tokens one
// transfer at a time through an output register and a hold register.
module jtc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  jtc_pkg::t_bundle  i_q_bundle,
    output logic              o_pop,
    jtc_out_if.source         o_out
);
    import jtc_pkg::*;

    logic   r_out_valid, n_out_valid;
    t_token r_out, n_out;
    logic   r_hold_valid, n_hold_valid;
    t_token r_hold, n_hold;
    logic   advance;

    assign advance = !r_out_valid || o_out.ready;
    assign o_pop = advance && !r_hold_valid && i_q_valid;

    // Second token of a bundle goes out before the next bundle is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out = r_out;
        n_hold_valid = r_hold_valid;
        n_hold = r_hold;
        if (advance) begin
            if (r_hold_valid) begin
                n_out_valid = 1'b1;
                n_out = r_hold;
                n_hold_valid = 1'b0;
            end else if (i_q_valid) begin
                n_out_valid = 1'b1;
                n_out = i_q_bundle.tok0;
                n_hold_valid = i_q_bundle.second;
                n_hold = i_q_bundle.tok1;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_hold <= n_hold;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.token_kind = r_out.kind;
    assign o_out.token_start = r_out.start_off;
    assign o_out.token_end = r_out.end_off;
    assign o_out.last_of_run = r_out.last;

endmodule

// ----- rtl/core/jtc_checker.sv -----
`timescale 1ns / 1ps

`include "json_token_classifier_assert.svh"

// Port-level checks on the token output.
module jtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [3:0]  i_kind,
    input logic [31:0] i_start,
    input logic [31:0] i_end,
    input logic        i_last
);
    import jtc_pkg::*;

    logic        is_punct;
    logic [31:0] span;

    assign is_punct = (i_kind >= KIND_COLON) && (i_kind <= KIND_RBRACE);
    assign span = i_end - i_start;

    // A stalled token keeps its contents.
    `JTC_ASSERT_NEXT(a_stall_hold, i_valid && !i_ready, i_valid && $stable(i_kind) && $stable(i_start) && $stable(i_end) && $stable(i_last), "token changed while stalled")

    // The end token is empty and closes its run.
    `JTC_ASSERT_NOW(a_end_token, i_valid && (i_kind == KIND_END), (i_start == i_end) && i_last, "malformed end token")

    // Punctuation covers one byte and is always the final token of its input.
    `JTC_ASSERT_NOW(a_punct_token, i_valid && is_punct, (span == 32'd1) && i_last, "malformed punctuation token")

    // Only a value or string token can be followed by another from the same input.
    `JTC_ASSERT_NOW(a_first_of_two, i_valid && !i_last, i_kind >= KIND_NUM, "bad first token of a pair")

endmodule

bind json_token_classifier jtc_checker u_jtc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_out.valid),
    .i_ready (o_out.ready),
    .i_kind  (o_out.token_kind),
    .i_start (o_out.token_start),
    .i_end   (o_out.token_end),
    .i_last  (o_out.last_of_run)
);

// ----- sim/jtc_token_checker.sv -----
`timescale 1ns / 1ps

// Scoreboard for the JSON token classifier.
// It watches both channels, works out the tokens that each input transfer
// should cause, and compares every output transfer with the oldest of them.
module jtc_token_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_token_kind,
    input  logic [31:0] i_token_start,
    input  logic [31:0] i_token_end,
    input  logic        i_last_of_run,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_kinds_seen
);
    import jtc_pkg::*;

    // Where the scanner stands between tokens.
    localparam logic [1:0] SCAN_IDLE   = 2'd0;
    localparam logic [1:0] SCAN_VALUE  = 2'd1;
    localparam logic [1:0] SCAN_STRING = 2'd2;
    localparam logic [1:0] SCAN_ESCAPE = 2'd3;

    // Classes of a bare value run while it is being read.
    localparam logic [3:0] CLS_INT      = 4'd0;
    localparam logic [3:0] CLS_SIGNED   = 4'd1;
    localparam logic [3:0] CLS_FLOAT    = 4'd2;
    localparam logic [3:0] CLS_NUMEXP   = 4'd3;
    localparam logic [3:0] CLS_FLOATEXP = 4'd4;
    localparam logic [3:0] CLS_WORD     = 4'd8;
    localparam logic [3:0] CLS_TEXT     = 4'd9;
    localparam logic [3:0] CLS_NONE     = 4'd15;

    logic [1:0] scan_mode;
    logic [3:0] run_class;
    t_offset    run_start;
    t_offset    next_offset;
    t_token     expected_tokens[$];
    logic [15:0] kinds_hit;

    function automatic t_token make_token(input logic [3:0] kind, input t_offset s,
                                          input t_offset e);
        t_token tok;
        tok.kind      = kind;
        tok.start_off = t_out_offset'(s);
        tok.end_off   = t_out_offset'(e);
        tok.last      = 1'b0;
        return tok;
    endfunction

    // Token kind that a finished value run carries.
    function automatic logic [3:0] kind_of_class(input logic [3:0] cls);
        if (cls <= CLS_FLOATEXP) return KIND_NUM + cls;
        if (cls == CLS_WORD) return KIND_WORD;
        return KIND_STRING;
    endfunction

    // Punctuation kind of a byte; KIND_END stands for no punctuation.
    function automatic logic [3:0] punct_kind(input logic [7:0] b);
        unique case (b)
            ":": return KIND_COLON;
            "[": return KIND_LBRACKET;
            "]": return KIND_RBRACKET;
            ",": return KIND_COMMA;
            "{": return KIND_LBRACE;
            "}": return KIND_RBRACE;
            default: return KIND_END;
        endcase
    endfunction

    // Bytes up to space and every byte with the top bit set separate tokens.
    function automatic logic is_blank(input logic [7:0] b);
        return (b < 8'h21) || (b >= 8'h80);
    endfunction

    // Promotes the class of a value run by one byte. Returns 1 when the byte
    // closes the token: only an exponent letter starting a run or after a number.
    function automatic logic class_step(input logic [7:0] b, input logic [3:0] cur,
                                        output logic [3:0] nxt);
        logic none;
        none = (cur == CLS_NONE);
        nxt  = cur;
        if (cur == CLS_TEXT) return 1'b0;
        if (b >= "0" && b <= "9") begin
            if (none) nxt = CLS_INT;
        end else if (b == "-" || b == "+") begin
            nxt = CLS_TEXT;
        end else if (b == ".") begin
            nxt = (none || cur < CLS_FLOAT) ? CLS_FLOAT : CLS_TEXT;
        end else if (b == "e" || b == "E") begin
            if (none || cur < CLS_FLOAT) begin
                nxt = CLS_NUMEXP;
                return 1'b1;
            end
            if (cur < CLS_NUMEXP) begin
                nxt = CLS_FLOATEXP;
                return 1'b1;
            end
            if (cur < CLS_WORD) nxt = CLS_WORD;
        end else if (b == "_" || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z")) begin
            if (none || cur < CLS_WORD) nxt = CLS_WORD;
        end else begin
            nxt = CLS_TEXT;
        end
        return 1'b0;
    endfunction

    // Advances the scanner by one input transfer and queues its tokens.
    task automatic predict_tokens(input logic [7:0] b, input logic eot);
        t_token     found[2];
        int         n;
        t_offset    pos;
        t_offset    nxt;
        logic [3:0] pk;
        logic [3:0] ncls;
        n   = 0;
        pos = next_offset;
        nxt = pos + t_offset'(1);
        pk  = punct_kind(b);
        if (eot) begin
            // Flush whatever is pending, then mark the end; the offset stays.
            if (scan_mode == SCAN_VALUE) begin
                found[n] = make_token(kind_of_class(run_class), run_start, pos);
                n++;
            end else if (scan_mode != SCAN_IDLE) begin
                found[n] = make_token(KIND_STRING, run_start, pos);
                n++;
            end
            found[n] = make_token(KIND_END, pos, pos);
            n++;
            scan_mode = SCAN_IDLE;
            run_class = CLS_NONE;
        end else begin
            unique case (scan_mode)
                SCAN_IDLE: begin
                    if (pk != KIND_END) begin
                        found[n] = make_token(pk, pos, nxt);
                        n++;
                    end else if (b == "\"") begin
                        scan_mode = SCAN_STRING;
                        run_start = nxt;
                    end else if (b == "-" || b == "+") begin
                        scan_mode = SCAN_VALUE;
                        run_class = CLS_SIGNED;
                        run_start = pos;
                    end else if (!is_blank(b)) begin
                        run_start = pos;
                        if (class_step(b, CLS_NONE, ncls)) begin
                            // A leading exponent letter is a token of its own.
                            found[n] = make_token(kind_of_class(ncls), pos, nxt);
                            n++;
                            run_class = CLS_NONE;
                        end else begin
                            run_class = ncls;
                            scan_mode = SCAN_VALUE;
                        end
                    end
                end
                SCAN_VALUE: begin
                    if (is_blank(b) || pk != KIND_END) begin
                        found[n] = make_token(kind_of_class(run_class), run_start, pos);
                        n++;
                        if (pk != KIND_END) begin
                            found[n] = make_token(pk, pos, nxt);
                            n++;
                        end
                        scan_mode = SCAN_IDLE;
                        run_class = CLS_NONE;
                    end else if (class_step(b, run_class, ncls)) begin
                        found[n] = make_token(kind_of_class(ncls), run_start, nxt);
                        n++;
                        scan_mode = SCAN_IDLE;
                        run_class = CLS_NONE;
                    end else begin
                        run_class = ncls;
                    end
                end
                SCAN_STRING: begin
                    if (b == "\"") begin
                        found[n] = make_token(KIND_STRING, run_start, pos);
                        n++;
                        scan_mode = SCAN_IDLE;
                    end else if (b == "\\") begin
                        scan_mode = SCAN_ESCAPE;
                    end
                end
                default: begin
                    scan_mode = SCAN_STRING;
                end
            endcase
            next_offset = nxt;
        end
        if (n > 0) found[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) expected_tokens.push_back(found[k]);
    endtask

    // Compare output transfers first, then account for the input transfer of
    // the same edge; a token never leaves in the cycle its byte is taken.
    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            scan_mode   = SCAN_IDLE;
            run_class   = CLS_NONE;
            run_start   = '0;
            next_offset = '0;
            kinds_hit   = '0;
            expected_tokens.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                kinds_hit[i_token_kind] = 1'b1;
                if (expected_tokens.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected token kind %0d span %0d..%0d last %0b",
                             $time, i_token_kind, i_token_start, i_token_end,
                             i_last_of_run);
                end else begin
                    want = expected_tokens.pop_front();
                    o_checked++;
                    if (i_token_kind !== want.kind || i_token_start !== want.start_off ||
                        i_token_end !== want.end_off || i_last_of_run !== want.last) begin
                        o_fail_count++;
                        $display("%0t: token mismatch, expected kind %0d span %0d..%0d last %0b",
                                 $time, want.kind, want.start_off, want.end_off, want.last);
                        $display("%0t:                 actual kind %0d span %0d..%0d last %0b",
                                 $time, i_token_kind, i_token_start, i_token_end,
                                 i_last_of_run);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_tokens(i_text_byte, i_end_of_text);
        end
        o_pending    = expected_tokens.size();
        o_kinds_seen = $countones(kinds_hit);
    end

endmodule

// ----- sim/tb_json_token_classifier.sv -----
`timescale 1ns / 1ps

// Testbench top: drives the byte channel and the output ready, and gives the
// verdict from the checker's counts.
module tb_json_token_classifier;

    localparam int RANDOM_ITEMS  = 400;
    localparam int DIRECTED_ITEMS = 25;
    localparam int IDLE_PCT      = 18;
    localparam int LIMIT_CYCLES  = 100000;
    localparam int HOLD_AT       = 150;
    localparam int HOLD_CYCLES   = 64;
    localparam int CALM_FROM     = 250;
    localparam int CALM_TO       = 330;
    localparam int RX_CALM_FROM  = 300;
    localparam int RX_CALM_TO    = 500;
    localparam int DRAIN_CYCLES  = 8;

    logic i_clk;
    logic i_rst_n;
    logic hold_req;
    logic hold_done = 1'b0;
    int   hold_left;
    int   rx_cycle;
    int   items_sent = 0;
    int   end_marks = 0;
    int   cycle_count;
    int   fail_count;
    int   pending;
    int   checked;
    int   kinds_seen;

    logic [7:0] punct_bytes [6] = '{":", "[", "]", ",", "{", "}"};

    jtc_in_if  in_ch ();
    jtc_out_if out_ch ();

    json_token_classifier i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    jtc_token_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_text_byte   (in_ch.text_byte),
        .i_end_of_text (in_ch.end_of_text),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_token_kind  (out_ch.token_kind),
        .i_token_start (out_ch.token_start),
        .i_token_end   (out_ch.token_end),
        .i_last_of_run (out_ch.last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_kinds_seen  (kinds_seen)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // One input transfer, preceded by random idle cycles outside the calm stretch.
    task automatic send_item(input logic [7:0] b, input logic eot);
        while (!(items_sent >= CALM_FROM && items_sent < CALM_TO) &&
               $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.text_byte   <= b;
        in_ch.end_of_text <= eot;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (eot) end_marks++;
        if (items_sent == HOLD_AT) hold_req <= 1'b1;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_item(s[k], 1'b0);
    endtask

    task automatic send_digits(input int count);
        for (int k = 0; k < count; k++) send_item(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
    endtask

    task automatic send_blank();
        if ($urandom_range(0, 1) != 0) send_item(8'($urandom_range(0, 32)), 1'b0);
        else send_item(8'($urandom_range(128, 255)), 1'b0);
    endtask

    // Optional sign, digits, fraction and exponent letter with more digits.
    task automatic send_number();
        if ($urandom_range(0, 3) == 0) send_item($urandom_range(0, 1) ? "-" : "+", 1'b0);
        send_digits($urandom_range(1, 4));
        if ($urandom_range(0, 2) == 0) begin
            send_item(".", 1'b0);
            send_digits($urandom_range(0, 3));
        end
        if ($urandom_range(0, 3) == 0) begin
            send_item($urandom_range(0, 1) ? "e" : "E", 1'b0);
            send_digits($urandom_range(0, 2));
        end
    endtask

    task automatic send_word();
        int         len;
        logic [7:0] c;
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 3))
                0: c = 8'(8'h61 + $urandom_range(0, 25));
                1: c = 8'(8'h41 + $urandom_range(0, 25));
                2: c = "_";
                default: c = 8'(8'h30 + $urandom_range(0, 9));
            endcase
            send_item(c, 1'b0);
        end
    endtask

    // Quoted text with escapes of any byte; now and then left unclosed.
    task automatic send_string();
        int         len;
        logic [7:0] c;
        len = $urandom_range(0, 6);
        send_item("\"", 1'b0);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                send_item("\\", 1'b0);
                send_item(8'($urandom_range(0, 255)), 1'b0);
            end else begin
                c = 8'($urandom_range(32, 126));
                if (c == "\"") c = "x";
                send_item(c, 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0) send_item("\"", 1'b0);
    endtask

    task automatic send_separator();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) send_item(punct_bytes[$urandom_range(0, 5)], 1'b0);
        else if (pick < 8) send_blank();
    endtask

    // Mostly well-formed JSON pieces, with some noise and end marks.
    task automatic send_fragment();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            send_number();
            send_separator();
        end else if (pick < 45) begin
            send_word();
            send_separator();
        end else if (pick < 65) begin
            send_string();
            send_separator();
        end else if (pick < 75) begin
            send_item(punct_bytes[$urandom_range(0, 5)], 1'b0);
        end else if (pick < 83) begin
            send_blank();
        end else if (pick < 93) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Output side: random stalls, one long hold-off to fill the block, and a
    // stretch with ready held high.
    initial begin
        out_ch.ready <= 1'b0;
        hold_left = 0;
        rx_cycle  = 0;
        forever begin
            @(posedge i_clk);
            rx_cycle++;
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else if (rx_cycle >= RX_CALM_FROM && rx_cycle < RX_CALM_TO) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d tokens outstanding.", cycle_count, pending);
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.text_byte   <= 8'h00;
        in_ch.end_of_text <= 1'b0;
        hold_req          <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: blanks at both ends of the byte range, every punctuation
        // byte, an escaped quote, a value closed by punctuation, a leading
        // exponent letter, a float closed by its exponent, a flush at end, an
        // empty string opened just before end, and repeated end marks.
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("{\"a\\\"\":-7]e1.Ew,[4");
        send_item(8'h5A, 1'b1);
        send_item("\"", 1'b0);
        send_item(8'h3C, 1'b1);
        send_item(8'hA5, 1'b1);
        send_item("}", 1'b0);

        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) send_fragment();
        in_ch.valid <= 1'b0;

        // Let every expected token arrive, then wait out the drain time set by DRAIN_CYCLES.
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d input transfers (%0d end marks) in %0d cycles, with one %0d-cycle hold-off.",
                 items_sent, end_marks, cycle_count, HOLD_CYCLES);
        $display("Checked %0d tokens covering %0d of 14 token kinds.", checked, kinds_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
